### sv/mi4_pkg.sv
// Shared constants and index helpers for the 4x4 matrix inverse block.
// No dependencies; imported by matrix4x4_inverse.
`default_nettype none
package mi4_pkg;

	localparam int ELEM_W        = 32;
	localparam int ELEMS         = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int MAG_W         = 96;   // magnitude of one triple product or adjugate entry
	localparam int ADJ_W         = 100;  // signed adjugate accumulator
	localparam int DET_W         = 132;  // signed determinant accumulator
	localparam int PROD_W        = 128;  // adjugate magnitude times element magnitude

	// Minor element n (0..8) of the 3x3 minor that skips position a and group b.
	function automatic logic [3:0] g_addr(input logic [1:0] a, input logic [1:0] b,
		input logic [3:0] n);
		logic [1:0] gi;
		logic [1:0] pi;
		logic [3:0] base;
		logic [1:0] grp;
		logic [1:0] pos;
		gi   = (n >= 4'd6) ? 2'd2 : ((n >= 4'd3) ? 2'd1 : 2'd0);
		base = (gi == 2'd2) ? 4'd6 : ((gi == 2'd1) ? 4'd3 : 4'd0);
		pi   = 2'(n - base);
		grp  = (gi >= b) ? 2'(gi + 2'd1) : gi;
		pos  = (pi >= a) ? 2'(pi + 2'd1) : pi;
		return {grp, pos};
	endfunction

	// Minor element index for factor j of triple product t of a 3x3 determinant.
	function automatic logic [3:0] trip_idx(input logic [2:0] t, input logic [1:0] j);
		logic [11:0] row;
		case (t)
			3'd0:    row = {4'd8, 4'd4, 4'd0};
			3'd1:    row = {4'd6, 4'd5, 4'd1};
			3'd2:    row = {4'd7, 4'd3, 4'd2};
			3'd3:    row = {4'd6, 4'd4, 4'd2};
			3'd4:    row = {4'd7, 4'd5, 4'd0};
			3'd5:    row = {4'd8, 4'd3, 4'd1};
			default: row = '0;
		endcase
		case (j)
			2'd0:    return row[3:0];
			2'd1:    return row[7:4];
			default: return row[11:8];
		endcase
	endfunction

	// Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
	function automatic logic [ELEM_W-1:0] mag32(input logic [ELEM_W-1:0] x);
		return x[ELEM_W-1] ? ELEM_W'(-x) : x;
	endfunction

endpackage
`default_nettype wire

### sv/matrix4x4_inverse.sv
// 4x4 matrix inverse by the adjugate, Q(FRAC_BITS) fixed point, on stream ports.
// Depends on mi4_pkg. 16 input transactions load the matrix; the block then forms
// the adjugate and the determinant (from the first-row terms) on one shared 32x32
// multiplier, and each of the 16 results passes a 32-step restoring divider and is
// held through any output stall. A singular matrix gives one zero result instead.
// One matrix in flight; input is refused while computing or emitting results.
// Reset (arst_n low, asynchronous) returns to loading at element 0.
`default_nettype none
module matrix4x4_inverse import mi4_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [ELEM_W-1:0] s_tdata,   // [31:0] element
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [ELEM_W-1:0] m_tdata,   // [31:0] element_res
	output logic                   m_tuser,   // [0] singular
	output logic                   m_tlast
);

	localparam int NW = ADJ_W + 2 * FRAC_BITS + 2;  // shifted numerator
	localparam int DW = DET_W + 1;                  // doubled divisor
	localparam int RW = DET_W + 2;                  // partial remainder

	localparam logic [4:0] ST_LOAD = 5'd0,  ST_RA   = 5'd1,  ST_RB   = 5'd2,
		ST_RC   = 5'd3,  ST_M1   = 5'd4,  ST_M2   = 5'd5,  ST_M3   = 5'd6,
		ST_ACC  = 5'd7,  ST_FIN  = 5'd8,  ST_DRA  = 5'd9,  ST_DM0  = 5'd10,
		ST_DM   = 5'd11, ST_DA   = 5'd12, ST_DADD = 5'd13, ST_QCHK = 5'd14,
		ST_QRD  = 5'd15, ST_QSET = 5'd16, ST_QDIV = 5'd17, ST_QRES = 5'd18,
		ST_OUT  = 5'd19;

	logic [4:0]        state_q;
	logic [3:0]        cnt_q;
	logic [3:0]        ent_q;
	logic [2:0]        trp_q;
	logic [1:0]        lmb_q;
	logic [4:0]        bit_q;
	logic [ELEM_W-1:0] mat_mem [ELEMS];
	logic [ADJ_W-1:0]  adj_mem [ELEMS];
	logic [ELEM_W-1:0] rdata_q;
	logic [ADJ_W-1:0]  adj_rdata_q;
	logic [3:0]        rd_addr;
	logic [ELEM_W-1:0] va_q, vb_q, vc_q, pp_hi_q, mul_x, mul_y;
	logic [63:0]       mul_q, lo_q;
	logic              sgn_q;
	logic signed [ADJ_W-1:0] acc_q, acc_fin;
	logic signed [DET_W-1:0] det_q;
	logic [MAG_W-1:0]  accm_q, trip;
	logic [PROD_W-1:0] dprod_q, dterm;
	logic [DET_W-1:0]  dmag_q;
	logic [DW-1:0]     dd_q;
	logic [RW-1:0]     rem_q, rem_sh;
	logic [NW-1:0]     num;
	logic [MAG_W-1:0]  am;
	logic [ELEM_W-1:0] nlo_q, quo_q, res;
	logic              neg_q, over_q;
	logic [ELEM_W-1:0] out_q;
	logic              sing_q, last_q;
	logic [1:0]        ea, eb;

	assign ea = ent_q[3:2];
	assign eb = ent_q[1:0];

	assign s_tready = (state_q == ST_LOAD);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = out_q;
	assign m_tuser  = sing_q;
	assign m_tlast  = last_q;

	// Select the matrix memory read address for the current step
	always_comb begin
		unique case (state_q)
			ST_RA:   rd_addr = g_addr(ea, eb, trip_idx(trp_q, 2'd0));
			ST_RB:   rd_addr = g_addr(ea, eb, trip_idx(trp_q, 2'd1));
			ST_RC:   rd_addr = g_addr(ea, eb, trip_idx(trp_q, 2'd2));
			ST_DRA:  rd_addr = {2'b00, ea};
			default: rd_addr = '0;
		endcase
	end

	// Memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mat_mem[cnt_q] <= s_tdata;
		end
		rdata_q <= mat_mem[rd_addr];
		if (state_q == ST_FIN) begin
			adj_mem[ent_q] <= acc_fin;
		end
		adj_rdata_q <= adj_mem[ent_q];
	end

	// Feed the shared multiplier
	always_comb begin
		mul_x = va_q;
		mul_y = vb_q;
		case (state_q)
			ST_M2: begin
				mul_x = mul_q[31:0];
				mul_y = vc_q;
			end
			ST_M3: begin
				mul_x = pp_hi_q;
				mul_y = vc_q;
			end
			ST_DM: begin
				case (lmb_q)
					2'd0:    mul_x = accm_q[31:0];
					2'd1:    mul_x = accm_q[63:32];
					default: mul_x = accm_q[95:64];
				endcase
				mul_y = vc_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_x * mul_y;
	end

	// Datapath terms
	always_comb begin
		trip    = {mul_q, 32'b0} + {32'b0, lo_q};
		acc_fin = (ea[0] ^ eb[0]) ? -acc_q : acc_q;
		case (lmb_q)
			2'd0:    dterm = PROD_W'(mul_q);
			2'd1:    dterm = PROD_W'(mul_q) << 32;
			default: dterm = PROD_W'(mul_q) << 64;
		endcase
		am     = MAG_W'(adj_rdata_q[ADJ_W-1] ? -adj_rdata_q : adj_rdata_q);
		num    = (NW'(am) << (2 * FRAC_BITS + 1)) + NW'(dmag_q);
		rem_sh = {rem_q[RW-2:0], nlo_q[bit_q]};
		if (neg_q) begin
			res = (over_q || quo_q > 32'h8000_0000) ? 32'h8000_0000 : ELEM_W'(-quo_q);
		end else begin
			res = (over_q || quo_q[ELEM_W-1]) ? 32'h7FFF_FFFF : quo_q;
		end
	end

	// Payload registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				acc_q <= '0;
				det_q <= '0;
			end
			ST_RB: begin
				va_q  <= mag32(rdata_q);
				sgn_q <= rdata_q[ELEM_W-1];
			end
			ST_RC: begin
				vb_q  <= mag32(rdata_q);
				sgn_q <= sgn_q ^ rdata_q[ELEM_W-1];
			end
			ST_M1: begin
				vc_q  <= mag32(rdata_q);
				sgn_q <= sgn_q ^ rdata_q[ELEM_W-1] ^ (trp_q >= 3'd3);
			end
			ST_M2: pp_hi_q <= mul_q[63:32];
			ST_M3: lo_q <= mul_q;
			ST_ACC: acc_q <= sgn_q ? acc_q - ADJ_W'(trip) : acc_q + ADJ_W'(trip);
			// keep first-row entries for the determinant, clear the rest
			ST_FIN: acc_q <= (eb == 2'd0) ? acc_fin : '0;
			ST_DM0: begin
				vc_q    <= mag32(rdata_q);
				sgn_q   <= acc_q[ADJ_W-1] ^ rdata_q[ELEM_W-1];
				accm_q  <= MAG_W'(acc_q[ADJ_W-1] ? -acc_q : acc_q);
				dprod_q <= '0;
			end
			ST_DA: dprod_q <= dprod_q + dterm;
			ST_DADD: begin
				det_q <= sgn_q ? det_q - DET_W'(dprod_q) : det_q + DET_W'(dprod_q);
				acc_q <= '0;
			end
			ST_QCHK: begin
				dmag_q <= det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
				dd_q   <= DW'(det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q)) << 1;
				out_q  <= '0;
				sing_q <= 1'b1;
				last_q <= 1'b1;
			end
			ST_QSET: begin
				nlo_q  <= num[31:0];
				rem_q  <= RW'(num >> 32);
				over_q <= (num >= ((NW + 32)'(dd_q) << 32));
				neg_q  <= adj_rdata_q[ADJ_W-1] ^ det_q[DET_W-1];
			end
			ST_QDIV: begin
				if (rem_sh >= RW'(dd_q)) begin
					rem_q <= rem_sh - RW'(dd_q);
					quo_q <= {quo_q[ELEM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[ELEM_W-2:0], 1'b0};
				end
			end
			ST_QRES: begin
				out_q  <= res;
				sing_q <= 1'b0;
				last_q <= (ent_q == 4'd15);
			end
			default: ;
		endcase
	end

	// Sequencer: load, adjugate, determinant, divide, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			ent_q   <= '0;
			trp_q   <= '0;
			lmb_q   <= '0;
			bit_q   <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (s_tvalid) begin
						cnt_q <= cnt_q + 4'd1;
						if (cnt_q == 4'd15) begin
							state_q <= ST_RA;
							ent_q   <= '0;
							trp_q   <= '0;
						end
					end
				end
				ST_RA:  state_q <= ST_RB;
				ST_RB:  state_q <= ST_RC;
				ST_RC:  state_q <= ST_M1;
				ST_M1:  state_q <= ST_M2;
				ST_M2:  state_q <= ST_M3;
				ST_M3:  state_q <= ST_ACC;
				ST_ACC: begin
					trp_q   <= trp_q + 3'd1;
					state_q <= (trp_q == 3'd5) ? ST_FIN : ST_RA;
				end
				ST_FIN, ST_DADD: begin
					if (state_q == ST_FIN && eb == 2'd0) begin
						state_q <= ST_DRA;
					end else if (ent_q == 4'd15) begin
						state_q <= ST_QCHK;
					end else begin
						ent_q   <= ent_q + 4'd1;
						trp_q   <= '0;
						state_q <= ST_RA;
					end
				end
				ST_DRA: state_q <= ST_DM0;
				ST_DM0: begin
					lmb_q   <= '0;
					state_q <= ST_DM;
				end
				ST_DM:  state_q <= ST_DA;
				ST_DA: begin
					lmb_q   <= lmb_q + 2'd1;
					state_q <= (lmb_q == 2'd2) ? ST_DADD : ST_DM;
				end
				ST_QCHK: begin
					ent_q   <= '0;
					state_q <= (det_q == '0) ? ST_OUT : ST_QRD;
				end
				ST_QRD: state_q <= ST_QSET;
				ST_QSET: begin
					bit_q   <= 5'd31;
					state_q <= ST_QDIV;
				end
				ST_QDIV: begin
					bit_q <= bit_q - 5'd1;
					if (bit_q == 5'd0) begin
						state_q <= ST_QRES;
					end
				end
				ST_QRES: state_q <= ST_OUT;
				ST_OUT: begin
					if (m_tready) begin
						if (last_q) begin
							state_q <= ST_LOAD;
						end else begin
							ent_q   <= ent_q + 4'd1;
							state_q <= ST_QRD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule
`default_nettype wire

### sv/matrix4x4_inverse_checker.sv
// Port-level checks for matrix4x4_inverse, bound to the top level.
// No package dependencies.
`default_nettype none
module matrix4x4_inverse_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [31:0] s_tdata,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);

	// Loading and emitting never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input ready while result pending");

	// A stalled result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// A singular report is a single zero transaction
	a_sing_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && m_tdata == 32'd0)
		else $error("singular result malformed");

	// After the last result the block is back to loading
	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("no return to loading after last result");

endmodule

bind matrix4x4_inverse matrix4x4_inverse_checker u_checker (.*);
`default_nettype wire
